@@ rtl/core/rgba_mip_downsample_2x2_macros.svh @@
// ----------------------------------------------------------------------------
// RGBA mip downsampler assertion macros
// Shared wrappers for the concurrent assertions of the downsampler core.
// ----------------------------------------------------------------------------
`ifndef RGBA_MIP_DOWNSAMPLE_2X2_MACROS_SVH
`define RGBA_MIP_DOWNSAMPLE_2X2_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold at every clock edge outside reset.
`define RMD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
		else $error(msg);

`endif

@@ rtl/core/rmd_pkg.sv @@
// ----------------------------------------------------------------------------
// RGBA mip downsampler package
// Geometry limits, field widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package rmd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;

	// Configuration field width and column/row counter widths.
	localparam int DIM_W = 13;
	localparam int XW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int OXW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int OYW   = YW - 1;

	localparam int CH_W   = 8;
	localparam int N_CH   = 4;
	localparam int PAIR_W = CH_W + 1;
	localparam int PIX_W  = N_CH * CH_W;
	localparam int LINE_W = N_CH * PAIR_W;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

	typedef logic [N_CH-1:0][CH_W-1:0]   pixel_t;
	typedef logic [N_CH-1:0][PAIR_W-1:0] pair_t;

	// Derived image geometry, kept in registers after each configuration write.
	typedef struct packed {
		logic           w_one;    // width is one: a pixel pairs with itself
		logic           w_trim;   // odd width above one: last column is dropped
		logic [XW-1:0]  w_last;   // last source column
		logic [OXW-1:0] dw_last;  // last destination column
		logic           h_one;
		logic           h_trim;
		logic [YW-1:0]  h_last;
		logic [OYW-1:0] dh_last;
	} geom_t;

	// One completed square on its way to the output stage.
	typedef struct packed {
		pair_t pair;   // horizontal pair sums of the lower row
		logic  h_one;  // upper row equals lower row
		logic  last;   // final destination pixel
	} item_t;

	// Zero counts as one, anything above the limit saturates.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int limit);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > limit) begin
			r = DIM_W'(limit);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/rmd_cfg.sv @@
// ----------------------------------------------------------------------------
// RGBA mip downsampler configuration registers
// Takes width and height writes and keeps the derived geometry in registers.
// ----------------------------------------------------------------------------
module rmd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmd_pkg::DIM_W-1:0]      cfg_data,
	output rmd_pkg::geom_t                 geom,
	output logic                           restart
);
	import rmd_pkg::*;

	geom_t            geom_q;
	logic [DIM_W-1:0] w_c;
	logic [DIM_W-1:0] h_c;
	logic [DIM_W-1:0] w_m1;
	logic [DIM_W-1:0] h_m1;
	logic [DIM_W-1:0] dw_m1;
	logic [DIM_W-1:0] dh_m1;
	logic             w_one_c;
	logic             h_one_c;

	assign cfg_ready = 1'b1;

	always_comb begin
		w_c     = clamp_dim(cfg_data, MAX_WIDTH);
		h_c     = clamp_dim(cfg_data, MAX_HEIGHT);
		w_one_c = (w_c == DIM_W'(1));
		h_one_c = (h_c == DIM_W'(1));
		w_m1    = w_c - DIM_W'(1);
		h_m1    = h_c - DIM_W'(1);
		dw_m1   = w_one_c ? '0 : (w_c >> 1) - DIM_W'(1);
		dh_m1   = h_one_c ? '0 : (h_c >> 1) - DIM_W'(1);
	end

	// Any write to a known register starts a new image.
	assign restart = cfg_valid && cfg_ready &&
		(cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.w_one   <= 1'b1;
			geom_q.w_trim  <= 1'b0;
			geom_q.w_last  <= '0;
			geom_q.dw_last <= '0;
			geom_q.h_one   <= 1'b1;
			geom_q.h_trim  <= 1'b0;
			geom_q.h_last  <= '0;
			geom_q.dh_last <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SRC_WIDTH: begin
					geom_q.w_one   <= w_one_c;
					geom_q.w_trim  <= !w_one_c && w_c[0];
					geom_q.w_last  <= XW'(w_m1);
					geom_q.dw_last <= OXW'(dw_m1);
				end
				REG_SRC_HEIGHT: begin
					geom_q.h_one   <= h_one_c;
					geom_q.h_trim  <= !h_one_c && h_c[0];
					geom_q.h_last  <= YW'(h_m1);
					geom_q.dh_last <= OYW'(dh_m1);
				end
				default: begin
				end
			endcase
		end
	end

	assign geom = geom_q;

endmodule

@@ rtl/core/rmd_line_ram.sv @@
// ----------------------------------------------------------------------------
// RGBA mip downsampler line RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmd_line_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 36,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/rmd_out.sv @@
// ----------------------------------------------------------------------------
// RGBA mip downsampler output stage
// Holds a completed square, forms the rounded averages and drives the result.
// ----------------------------------------------------------------------------
module rmd_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  rmd_pkg::item_t             item,
	input  rmd_pkg::pair_t             upper_mem,
	output logic                       ready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [rmd_pkg::PIX_W-1:0]  m_tdata,
	output logic                       m_tlast
);
	import rmd_pkg::*;

	item_t                item_s1;
	logic                 valid_s1;
	logic                 tvalid_q;
	pixel_t               tdata_q;
	logic                 tlast_q;
	logic                 out_adv;
	pixel_t               avg;
	logic [PAIR_W-1:0]    upper;
	logic [PAIR_W:0]      sum;

	assign out_adv = !tvalid_q || m_tready;
	assign ready   = !valid_s1 || out_adv;

	// Rounded average of the four source pixels: (upper + lower + 2) / 4.
	always_comb begin
		upper = '0;
		sum   = '0;
		avg   = '0;
		for (int c = 0; c < N_CH; c++) begin
			upper  = item_s1.h_one ? item_s1.pair[c] : upper_mem[c];
			sum    = {1'b0, upper} + {1'b0, item_s1.pair[c]} + (PAIR_W + 1)'(2);
			avg[c] = sum[PAIR_W:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (in_valid) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				tvalid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			item_s1 <= item;
		end
		if (out_adv) begin
			tdata_q <= avg;
			tlast_q <= item_s1.last;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

endmodule

@@ rtl/core/rgba_mip_downsample_2x2.sv @@
// ----------------------------------------------------------------------------
// RGBA mip downsampler, 2x2 box filter
// Streams RGBA8 source pixels in raster order and produces the next mip level.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: source pixel
// m_*       out        m_tvalid/m_tready  m_tdata: averaged pixel, m_tlast: end of image
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data: source width/height
//
// One source pixel is taken per clock when the output side keeps up; the pixel
// that completes a square is held in the square register, then in the output register.
// The single line RAM port pair sees one write or one read per pixel.
// Reset clears counters, the held pixel and the pipeline; the line RAM is not
// cleared, since each entry is written in an upper row before its lower row reads it.
// A stalled output holds its result while the stage behind it still takes one more
// request, so the input only stops when both stages are full.
//
module rgba_mip_downsample_2x2 (
	input  logic                          clk,
	input  logic                          arst_n,
	// Source pixel stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rmd_pkg::PIX_W-1:0]     s_tdata,   // in_red, in_green, in_blue, in_alpha
	// Destination pixel stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rmd_pkg::PIX_W-1:0]     m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic                          m_tlast,   // last_pixel
	// Register writes: index 0 is the source width, index 1 the source height.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmd_pkg::DIM_W-1:0]     cfg_data
);
	import rmd_pkg::*;

	geom_t          geom;
	logic           restart;
	logic [XW-1:0]  x_q;
	logic [YW-1:0]  y_q;
	pixel_t         held_q;
	pixel_t         px;
	pair_t          pair;
	pair_t          upper_mem;
	logic [LINE_W-1:0] ram_rdata;
	logic [OXW-1:0] ox;
	logic [OYW-1:0] oy;
	logic           accept;
	logic           col_in;
	logic           row_in;
	logic           have_pair;
	logic           store;
	logic           emit;
	logic           x_end;
	logic           y_end;
	logic           ram_we;
	logic           ram_re;
	logic           stage_ready;
	item_t          item;

	rmd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.restart   (restart)
	);

	assign s_tready = stage_ready;
	assign accept   = s_tvalid && s_tready;
	assign px       = s_tdata;

	// Position decode for the pixel on the input. An odd dimension above one
	// drops its last column or row; a dimension of one pairs a pixel with itself.
	always_comb begin
		x_end     = (x_q == geom.w_last);
		y_end     = (y_q == geom.h_last);
		col_in    = !(geom.w_trim && x_end);
		row_in    = !(geom.h_trim && y_end);
		have_pair = geom.w_one || (col_in && x_q[0]);
		store     = have_pair && !geom.h_one && row_in && !y_q[0];
		emit      = have_pair && (geom.h_one || (row_in && y_q[0]));
		ox        = OXW'(x_q >> 1);
		oy        = OYW'(y_q >> 1);
		for (int c = 0; c < N_CH; c++) begin
			pair[c] = geom.w_one ? {px[c], 1'b0} : {1'b0, held_q[c]} + {1'b0, px[c]};
		end
	end

	// Column and row counters plus the left pixel of the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			held_q <= '0;
		end else if (restart) begin
			x_q    <= '0;
			y_q    <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (!geom.w_one && col_in && !x_q[0]) begin
				held_q <= px;
			end
			if (x_end) begin
				x_q <= '0;
				y_q <= y_end ? '0 : y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// Upper-row pair sums are parked in the line RAM and read back one row later.
	assign ram_we = accept && store;
	assign ram_re = accept && emit && !geom.h_one;

	rmd_line_ram #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (LINE_W),
		.AW    (OXW)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ox),
		.wdata (pair),
		.re    (ram_re),
		.raddr (ox),
		.rdata (ram_rdata)
	);

	assign upper_mem = ram_rdata;

	always_comb begin
		item.pair  = pair;
		item.h_one = geom.h_one;
		item.last  = (ox == geom.dw_last) && (oy == geom.dh_last);
	end

	rmd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && emit),
		.item      (item),
		.upper_mem (upper_mem),
		.ready     (stage_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

`include "rgba_mip_downsample_2x2_macros.svh"

	`RMD_ASSERT_IMPLY(a_ram_single_access, clk, arst_n, ram_we, !ram_re, "line RAM written and read in one cycle")
	`RMD_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, !s_tready, m_tvalid, "input stalled with an empty output register")
	`RMD_ASSERT_ALWAYS(a_column_in_range, clk, arst_n, x_q <= geom.w_last, "column counter beyond image width")
	`RMD_ASSERT_ALWAYS(a_row_in_range, clk, arst_n, y_q <= geom.h_last, "row counter beyond image height")

endmodule
